FILE: design/usp_pkg.sv
// ----------------------------------------------------------------------------
// usp_pkg: shared types and constants for the Ulam spiral prime map
// Holds the mode and status codes, the sequencer states and the defaults.
// ----------------------------------------------------------------------------
package usp_pkg;

    localparam int unsigned DEF_MAX_SIDE = 64;
    localparam int unsigned STORE_AW     = 12;
    localparam logic [5:0]  SIDE_RESET   = 6'd63;

    typedef enum logic [1:0] {
        MODE_BUILD = 2'd0,
        MODE_QNUM  = 2'd1,
        MODE_QCELL = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_NOBUILD = 2'd2,
        ST_UNUSED  = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_FILL,
        S_SV_RD,
        S_SV_CHK,
        S_SV_CLR,
        S_Q_RD1,
        S_Q_RD2,
        S_Q_RD3,
        S_Q_OUT
    } t_state;

endpackage

FILE: design/usp_ram.sv
// ----------------------------------------------------------------------------
// usp_ram: generic single-port RAM with registered read
// One read per cycle, plus a write when i_we is high, at a single address.
// ----------------------------------------------------------------------------
module usp_ram #(
    parameter int unsigned WIDTH = 12,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/ulam_spiral_prime_map.sv
// ----------------------------------------------------------------------------
// ulam_spiral_prime_map: Ulam spiral layout with prime flags
// Builds a spiral of 1..S*S in RAM, sieves it, and answers lookups.
// ----------------------------------------------------------------------------
// A build request (mode 0) walks the spiral of 1..S*S, sets the S*S+1 prime
// flags, then reads each sieve candidate p with p*p <= S*S and clears the
// multiples of each flagged one, and then ends the sieve, all on one RAM port
// per store. A query makes two chained RAM reads through the states S_Q_RD1,
// S_Q_RD2, S_Q_RD3 and S_Q_OUT; a new request is taken only once the last
// result has strobed. busy is high from the accepted request until the result
// strobe; results appear on o_valid for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module ulam_spiral_prime_map #(
    parameter int unsigned MAX_SIDE = usp_pkg::DEF_MAX_SIDE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_side,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_mode,
    input  logic [11:0] i_number,
    input  logic [5:0]  i_row,
    input  logic [5:0]  i_col,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [11:0] o_number_out,
    output logic [5:0]  o_row_out,
    output logic [5:0]  o_col_out,
    output logic        o_is_prime
);

    localparam int unsigned AW = usp_pkg::STORE_AW;
    localparam logic [6:0] SMAX =
        (MAX_SIDE >= 64) ? 7'd63 : 7'((MAX_SIDE % 2 == 0) ? MAX_SIDE - 1 : MAX_SIDE);

    usp_pkg::t_state r_state, n_state;
    logic [5:0]  r_side;
    logic        r_built, n_built;
    logic [6:0]  r_bside, n_bside;
    logic [12:0] r_last, n_last;      // S*S
    logic [12:0] r_num, n_num;        // walk number / fill index / sieve k
    logic [5:0]  r_r, n_r, r_c, n_c;
    logic [6:0]  r_run, n_run;
    logic [7:0]  r_i, n_i;
    logic [12:0] r_p, n_p;            // sieve candidate
    logic [1:0]  r_mode, n_mode;
    logic [11:0] r_qn, n_qn;
    logic [5:0]  r_qr, n_qr, r_qc, n_qc;
    logic        r_valid, n_valid;
    logic [1:0]  r_ost, n_ost;
    logic [11:0] r_on, n_on;
    logic [5:0]  r_or, n_or, r_oc, n_oc;
    logic        r_op, n_op;

    // RAM ports
    logic            pf_we, cn_we, nc_we;
    logic [AW-1:0]   pf_a, cn_a, nc_a;
    logic            pf_wd, pf_rd;
    logic [11:0]     cn_wd, cn_rd, nc_wd, nc_rd;

    usp_ram #(.WIDTH(1), .DEPTH(4096)) u_pf (
        .i_clk(i_clk), .i_we(pf_we), .i_addr(pf_a), .i_wdata(pf_wd), .o_rdata(pf_rd));
    usp_ram #(.WIDTH(12), .DEPTH(4096)) u_cn (
        .i_clk(i_clk), .i_we(cn_we), .i_addr(cn_a), .i_wdata(cn_wd), .o_rdata(cn_rd));
    usp_ram #(.WIDTH(12), .DEPTH(4096)) u_nc (
        .i_clk(i_clk), .i_we(nc_we), .i_addr(nc_a), .i_wdata(nc_wd), .o_rdata(nc_rd));

    logic [6:0]  eff_side;
    logic [12:0] sq;
    logic [25:0] pp;

    always_comb begin
        eff_side = {1'b0, r_side | 6'd1};
        if (eff_side > SMAX) eff_side = SMAX;
        sq = 13'(eff_side * eff_side);
        pp = 26'(r_p * r_p);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= usp_pkg::S_IDLE;
            r_side  <= usp_pkg::SIDE_RESET;
            r_built <= 1'b0;
            r_bside <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_side <= i_cfg_side;
            r_built <= n_built;
            r_bside <= n_bside;
            r_valid <= n_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_last <= n_last; r_num <= n_num; r_r <= n_r; r_c <= n_c;
        r_run <= n_run; r_i <= n_i; r_p <= n_p; r_mode <= n_mode;
        r_qn <= n_qn; r_qr <= n_qr; r_qc <= n_qc;
        r_ost <= n_ost; r_on <= n_on; r_or <= n_or; r_oc <= n_oc; r_op <= n_op;
    end

    // sequencer
    always_comb begin
        n_state = r_state; n_built = r_built; n_bside = r_bside;
        n_last = r_last; n_num = r_num; n_r = r_r; n_c = r_c;
        n_run = r_run; n_i = r_i; n_p = r_p; n_mode = r_mode;
        n_qn = r_qn; n_qr = r_qr; n_qc = r_qc;
        n_valid = 1'b0; n_ost = r_ost; n_on = r_on; n_or = r_or; n_oc = r_oc;
        n_op = r_op;
        pf_we = 1'b0; pf_a = '0; pf_wd = 1'b0;
        cn_we = 1'b0; cn_a = '0; cn_wd = '0;
        nc_we = 1'b0; nc_a = '0; nc_wd = '0;
        unique case (r_state)
            usp_pkg::S_IDLE: begin
                if (start) begin
                    n_mode = i_mode; n_qn = i_number; n_qr = i_row; n_qc = i_col;
                    n_ost = usp_pkg::ST_OK; n_on = '0; n_or = '0; n_oc = '0; n_op = 1'b0;
                    if (i_mode == usp_pkg::MODE_BUILD) begin
                        n_last = sq;
                        n_bside = eff_side;
                        n_r = eff_side[6:1]; n_c = eff_side[6:1];
                        n_num = 13'd1; n_run = 7'd1; n_i = '0;
                        n_state = usp_pkg::S_WALK;
                    end else begin
                        n_state = usp_pkg::S_Q_RD1;
                    end
                end
            end
            // place one number per cycle, then step the walk
            usp_pkg::S_WALK: begin
                cn_we = 1'b1; cn_a = r_num[11:0]; cn_wd = {r_r, r_c};
                nc_we = 1'b1; nc_a = {r_r, r_c}; nc_wd = r_num[11:0];
                n_num = r_num + 13'd1;
                if (r_i < {r_run, 1'b0} - 8'd1) n_i = r_i + 8'd1;
                else begin n_i = '0; n_run = r_run + 7'd1; end
                if (r_run[0]) begin
                    if ({1'b0, r_i} < {2'b0, r_run}) n_c = r_c + 6'd1; else n_r = r_r - 6'd1;
                end else begin
                    if ({1'b0, r_i} < {2'b0, r_run}) n_c = r_c - 6'd1; else n_r = r_r + 6'd1;
                end
                if (r_num == r_last) begin
                    n_num = '0; n_state = usp_pkg::S_FILL;
                end
            end
            // prime flags 2..S*S set, 0 and 1 cleared
            usp_pkg::S_FILL: begin
                pf_we = 1'b1; pf_a = r_num[11:0]; pf_wd = (r_num > 13'd1);
                n_num = r_num + 13'd1;
                if (r_num == r_last) begin
                    n_p = 13'd2; n_state = usp_pkg::S_SV_RD;
                end
            end
            usp_pkg::S_SV_RD: begin
                pf_a = r_p[11:0];
                if (pp > {13'd0, r_last}) begin
                    n_built = 1'b1; n_valid = 1'b1;
                    n_state = usp_pkg::S_IDLE;
                end else begin
                    n_num = pp[12:0]; n_state = usp_pkg::S_SV_CHK;
                end
            end
            usp_pkg::S_SV_CHK: begin
                if (pf_rd) n_state = usp_pkg::S_SV_CLR;
                else begin n_p = r_p + 13'd1; n_state = usp_pkg::S_SV_RD; end
            end
            usp_pkg::S_SV_CLR: begin
                pf_we = 1'b1; pf_a = r_num[11:0]; pf_wd = 1'b0;
                if ({1'b0, r_num} + {1'b0, r_p} > {1'b0, r_last}) begin
                    n_p = r_p + 13'd1; n_state = usp_pkg::S_SV_RD;
                end else n_num = r_num + r_p;
            end
            // query: first read
            usp_pkg::S_Q_RD1: begin
                cn_a = r_qn; nc_a = {r_qr, r_qc}; pf_a = r_qn;
                n_state = usp_pkg::S_Q_RD2;
            end
            usp_pkg::S_Q_RD2: begin
                pf_a = nc_rd;
                n_state = usp_pkg::S_Q_RD3;
                if (r_mode == usp_pkg::MODE_QNUM) begin
                    n_or = cn_rd[11:6]; n_oc = cn_rd[5:0]; n_op = pf_rd;
                end else n_on = nc_rd;
            end
            usp_pkg::S_Q_RD3: begin
                if (r_mode == usp_pkg::MODE_QCELL) n_op = pf_rd;
                n_state = usp_pkg::S_Q_OUT;
            end
            usp_pkg::S_Q_OUT: begin
                n_valid = 1'b1; n_state = usp_pkg::S_IDLE;
                if (r_mode == usp_pkg::MODE_NONE || r_mode == usp_pkg::MODE_BUILD) begin
                    n_ost = usp_pkg::ST_RANGE;
                    n_on = '0; n_or = '0; n_oc = '0; n_op = 1'b0;
                end else if (!r_built) begin
                    n_ost = usp_pkg::ST_NOBUILD;
                    n_on = '0; n_or = '0; n_oc = '0; n_op = 1'b0;
                end else if (r_mode == usp_pkg::MODE_QNUM) begin
                    n_on = r_qn;
                    if (r_qn == '0 || {2'b0, r_qn} > {1'b0, r_last}) begin
                        n_ost = usp_pkg::ST_RANGE; n_or = '0; n_oc = '0; n_op = 1'b0;
                    end
                end else begin
                    n_or = r_qr; n_oc = r_qc;
                    if ({1'b0, r_qr} >= r_bside || {1'b0, r_qc} >= r_bside) begin
                        n_ost = usp_pkg::ST_RANGE; n_on = '0; n_op = 1'b0;
                    end
                end
            end
            default: n_state = usp_pkg::S_IDLE;
        endcase
        if (r_state == usp_pkg::S_SV_RD && pp > {13'd0, r_last}) begin
            n_ost = usp_pkg::ST_OK; n_on = '0; n_or = '0; n_oc = '0; n_op = 1'b0;
        end
    end

    assign busy         = (r_state != usp_pkg::S_IDLE);
    assign o_valid      = r_valid;
    assign o_status     = r_ost;
    assign o_number_out = r_on;
    assign o_row_out    = r_or;
    assign o_col_out    = r_oc;
    assign o_is_prime   = r_op;

    // a result always ends a request, so it never appears while busy
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");
    // an accepted request makes the block busy next cycle
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("request not taken");
    // a no-build status is only reported while no build has finished
    a_nobuild: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == usp_pkg::ST_NOBUILD) |-> !r_built)
        else $error("no-build status after build");

endmodule

FILE: bench/tb_ulam_spiral_prime_map.sv
// ----------------------------------------------------------------------------
// tb_ulam_spiral_prime_map: self-checking bench for the Ulam spiral prime map
// Drives builds and lookups through the start/busy handshake, predicts every
// response from a local spiral and sieve, and checks each strobed result.
// ----------------------------------------------------------------------------
module tb_ulam_spiral_prime_map;

    typedef struct packed {
        usp_pkg::t_mode mode;
        logic [11:0]    number;
        logic [5:0]     row;
        logic [5:0]     col;
    } t_request;

    typedef struct packed {
        usp_pkg::t_status status;
        logic [11:0]      number;
        logic [5:0]       row;
        logic [5:0]       col;
        logic             prime;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_side;
    logic        start;
    logic        busy;
    logic [1:0]  i_mode;
    logic [11:0] i_number;
    logic [5:0]  i_row;
    logic [5:0]  i_col;
    logic        o_valid;
    logic [1:0]  o_status;
    logic [11:0] o_number_out;
    logic [5:0]  o_row_out;
    logic [5:0]  o_col_out;
    logic        o_is_prime;

    ulam_spiral_prime_map u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_side(i_cfg_side),
        .start(start), .busy(busy),
        .i_mode(i_mode), .i_number(i_number), .i_row(i_row), .i_col(i_col),
        .o_valid(o_valid), .o_status(o_status), .o_number_out(o_number_out),
        .o_row_out(o_row_out), .o_col_out(o_col_out), .o_is_prime(o_is_prime)
    );

    // Predictor state: the grid as the last build left it
    logic        sieve_flag [4096];
    logic [11:0] cell_by_num [4096];
    logic [11:0] num_by_cell [4096];
    logic        grid_built;
    int unsigned side_reg;
    int unsigned grid_side;

    t_request request_q [$];
    t_answer  answer_q [$];
    int       errors;
    int       idle_cycles;
    int       calm_left;
    logic     drive_busy;
    int       grid_sides [$];
    logic     accepted;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Lay out the spiral and sieve it, using the current side register
    task automatic build_grid();
        int unsigned s, last, r, c, num, run, i, k;
        s = side_reg | 1;
        if (s > usp_pkg::DEF_MAX_SIDE)
            s = (usp_pkg::DEF_MAX_SIDE % 2) ? usp_pkg::DEF_MAX_SIDE
                                            : usp_pkg::DEF_MAX_SIDE - 1;
        last = s * s;
        r = s / 2;
        c = s / 2;
        cell_by_num[1] = 12'((r << 6) | c);
        num_by_cell[(r << 6) | c] = 12'd1;
        num = 2;
        run = 1;
        while (num <= last) begin
            for (i = 0; i < 2 * run && num <= last; i++) begin
                if (run % 2) begin
                    if (i < run) c++; else r--;
                end else begin
                    if (i < run) c--; else r++;
                end
                cell_by_num[num] = 12'((r << 6) | c);
                num_by_cell[((r << 6) | c) & 4095] = 12'(num);
                num++;
            end
            run++;
        end
        for (k = 0; k <= last; k++) sieve_flag[k] = 1'b1;
        sieve_flag[0] = 1'b0;
        sieve_flag[1] = 1'b0;
        for (i = 2; i * i <= last; i++) begin
            if (sieve_flag[i]) begin
                for (k = i * i; k <= last; k += i) sieve_flag[k] = 1'b0;
            end
        end
        grid_side = s;
        grid_built = 1'b1;
    endtask

    function automatic t_answer lookup(t_request rq);
        t_answer a;
        a = '0;
        a.status = usp_pkg::ST_OK;
        if (rq.mode == usp_pkg::MODE_NONE) begin
            a.status = usp_pkg::ST_RANGE;
        end else if (!grid_built) begin
            a.status = usp_pkg::ST_NOBUILD;
        end else if (rq.mode == usp_pkg::MODE_QNUM) begin
            a.number = rq.number;
            if (rq.number == 0 || rq.number > grid_side * grid_side) begin
                a.status = usp_pkg::ST_RANGE;
            end else begin
                a.row = cell_by_num[rq.number][11:6];
                a.col = cell_by_num[rq.number][5:0];
                a.prime = sieve_flag[rq.number];
            end
        end else if (rq.mode == usp_pkg::MODE_QCELL) begin
            a.row = rq.row;
            a.col = rq.col;
            if (rq.row >= grid_side || rq.col >= grid_side) begin
                a.status = usp_pkg::ST_RANGE;
            end else begin
                a.number = num_by_cell[{rq.row, rq.col}];
                a.prime = sieve_flag[a.number];
            end
        end
        return a;
    endfunction

    // Accept side: predict the response of every request taken
    always @(posedge i_clk) begin
        accepted = i_rst_n && start && !busy;
        if (accepted) begin
            t_request rq;
            rq = request_q.pop_front();
            if (rq.mode == usp_pkg::MODE_BUILD) begin
                build_grid();
                answer_q.push_back('0);
            end else begin
                answer_q.push_back(lookup(rq));
            end
        end
    end

    // Driver: offers queued requests at the falling edge, with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !accepted) begin
            // hold the pending request until it is taken
        end else begin
            if (calm_left > 0) calm_left <= calm_left - 1;
            if (request_q.size() > 0 && !drive_busy &&
                (calm_left > 0 || $urandom_range(99) >= 30)) begin
                start    <= 1'b1;
                i_mode   <= request_q[0].mode;
                i_number <= request_q[0].number;
                i_row    <= request_q[0].row;
                i_col    <= request_q[0].col;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d number=%0d", $time,
                         o_status, o_number_out);
                errors++;
            end else begin
                t_answer ex;
                ex = answer_q.pop_front();
                if (o_status !== ex.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             ex.status, o_status);
                    errors++;
                end
                if (o_number_out !== ex.number) begin
                    $display("%0t: number_out expected %0d actual %0d", $time,
                             ex.number, o_number_out);
                    errors++;
                end
                if (o_row_out !== ex.row) begin
                    $display("%0t: row_out expected %0d actual %0d", $time,
                             ex.row, o_row_out);
                    errors++;
                end
                if (o_col_out !== ex.col) begin
                    $display("%0t: col_out expected %0d actual %0d", $time,
                             ex.col, o_col_out);
                    errors++;
                end
                if (o_is_prime !== ex.prime) begin
                    $display("%0t: is_prime expected %0d actual %0d", $time,
                             ex.prime, o_is_prime);
                    errors++;
                end
            end
        end
    end

    // Watchdog: a build of side 63 is the longest request, so allow plenty
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic t_request make_req(usp_pkg::t_mode m, int unsigned n,
                                          int unsigned r, int unsigned c);
        t_request rq;
        rq.mode = m;
        rq.number = 12'(n);
        rq.row = 6'(r);
        rq.col = 6'(c);
        return rq;
    endfunction

    // Random lookup, mostly within the built grid
    function automatic t_request rand_query(int unsigned s);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
            return make_req(usp_pkg::MODE_QNUM, $urandom_range(s * s, 1), $urandom,
                            $urandom);
        if (pick < 85)
            return make_req(usp_pkg::MODE_QCELL, $urandom, $urandom_range(s - 1),
                            $urandom_range(s - 1));
        if (pick < 90)
            return make_req(usp_pkg::MODE_QNUM, $urandom, $urandom, $urandom);
        if (pick < 96)
            return make_req(usp_pkg::MODE_QCELL, $urandom, $urandom, $urandom);
        return make_req(usp_pkg::MODE_NONE, $urandom, $urandom, $urandom);
    endfunction

    // Wait for every queued request to be taken and answered, then settle
    task automatic drain();
        while (request_q.size() != 0 || answer_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_side(int unsigned v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_side <= 6'(v);
        side_reg = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int unsigned eff_side(int unsigned v);
        int unsigned s;
        s = v | 1;
        return (s > 63) ? 63 : s;
    endfunction

    initial begin
        int unsigned s, n;
        errors = 0;
        idle_cycles = 0;
        calm_left = 0;
        drive_busy = 1'b0;
        grid_built = 1'b0;
        side_reg = usp_pkg::SIDE_RESET;
        grid_side = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_side = '0;
        start = 1'b0;
        i_mode = '0;
        i_number = '0;
        i_row = '0;
        i_col = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: lookups before any build, then the reset side of 63
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 5, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QCELL, 0, 1, 1));
        request_q.push_back(make_req(usp_pkg::MODE_NONE, 4095, 63, 63));
        request_q.push_back(make_req(usp_pkg::MODE_BUILD, 4095, 63, 63));
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 1, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 2, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 3969, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 3970, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 0, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 4095, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 3967, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QCELL, 0, 31, 31));
        request_q.push_back(make_req(usp_pkg::MODE_QCELL, 0, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QCELL, 0, 62, 62));
        request_q.push_back(make_req(usp_pkg::MODE_QCELL, 0, 63, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QCELL, 0, 0, 63));
        request_q.push_back(make_req(usp_pkg::MODE_NONE, 0, 0, 0));
        drain();

        // Side written after a build leaves the old grid in place
        write_side(4);
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 3000, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QCELL, 0, 40, 40));
        request_q.push_back(make_req(usp_pkg::MODE_BUILD, 0, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 25, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QNUM, 26, 0, 0));
        request_q.push_back(make_req(usp_pkg::MODE_QCELL, 0, 4, 4));
        drain();

        // Random phases over many sides; small grids dominate, 0 and 63 included
        grid_sides = '{0, 1, 2, 63, 7, 62, 13, 5, 10, 3, 21, 9, 33, 17, 6, 44, 11, 1, 15, 63};
        foreach (grid_sides[p]) begin
            write_side(grid_sides[p]);
            s = eff_side(grid_sides[p]);
            calm_left = (p % 4 == 1) ? 40 : 0;
            request_q.push_back(make_req(usp_pkg::MODE_BUILD, $urandom, $urandom,
                                         $urandom));
            for (n = 0; n < 65; n++) begin
                if ($urandom_range(199) == 0)
                    request_q.push_back(make_req(usp_pkg::MODE_BUILD, $urandom,
                                                 $urandom, $urandom));
                else
                    request_q.push_back(rand_query(s));
            end
            drain();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && answer_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
